/* hw/rtl/cldd_pkg.sv */
// Shared types and codes for the copy/literal delta decoder.
`timescale 1ns / 1ps
package cldd_pkg;

  localparam logic [1:0] KIND_LITERAL = 2'd0;
  localparam logic [1:0] KIND_COPY    = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TRUNCATED = 3'd1;
  localparam logic [2:0] ST_BASE      = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_OVERRUN   = 3'd4;
  localparam logic [2:0] ST_MISMATCH  = 3'd5;

  localparam logic [2:0] REG_PAYLOAD_SIZE  = 3'd0;
  localparam logic [2:0] REG_BASE_SIZE     = 3'd1;
  localparam logic [2:0] REG_OUT_CAPACITY  = 3'd2;
  localparam logic [2:0] REG_DECLARED_SIZE = 3'd3;
  localparam logic [2:0] REG_LENGTH_MASK   = 3'd4;
  localparam logic [2:0] REG_LENGTH_BIAS   = 3'd5;

  localparam int RES_DATA_W = 96;

  typedef struct packed {
    logic [31:0] payload_size;
    logic [31:0] base_size;
    logic [31:0] out_capacity;
    logic [31:0] declared_size;
    logic [15:0] length_mask;
    logic [15:0] length_bias;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] copy_offset;
    logic [16:0] copy_length;
    logic [2:0]  status;
    logic [31:0] bytes_out;
    logic        last;
  } res_t;

endpackage

/* hw/rtl/cldd_parser.sv */
// Command parser: parse state, bound checks and up to two results per word.
`timescale 1ns / 1ps
module cldd_parser
  import cldd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_fire,
  input  logic [7:0] in_byte,
  output logic [1:0] res_count,
  output res_t       res0,
  output res_t       res1
);

  localparam logic [1:0] PH_CMD_LO  = 2'd0;
  localparam logic [1:0] PH_CMD_HI  = 2'd1;
  localparam logic [1:0] PH_OFFSET  = 2'd2;
  localparam logic [1:0] PH_LITERAL = 2'd3;

  logic [31:0] payload_pos, payload_pos_next;
  logic [31:0] out_pos, out_pos_next;
  logic [1:0]  phase, phase_next;
  logic [15:0] command_word, command_word_next;
  logic [31:0] offset_accum, offset_accum_next;
  logic [1:0]  byte_count, byte_count_next;
  logic [15:0] literal_left, literal_left_next;
  logic        halted, halted_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_pos  <= '0;
      out_pos      <= '0;
      phase        <= PH_CMD_LO;
      command_word <= '0;
      offset_accum <= '0;
      byte_count   <= '0;
      literal_left <= '0;
      halted       <= 1'b0;
    end else begin
      payload_pos  <= payload_pos_next;
      out_pos      <= out_pos_next;
      phase        <= phase_next;
      command_word <= command_word_next;
      offset_accum <= offset_accum_next;
      byte_count   <= byte_count_next;
      literal_left <= literal_left_next;
      halted       <= halted_next;
    end
  end

  logic [31:0] pos_inc;
  logic [31:0] left;
  logic [15:0] word;
  logic [31:0] full_off;
  logic [16:0] copy_len;
  logic [31:0] base_room;
  logic [31:0] cap_room;
  logic        cap_bad;
  logic        main_en;
  res_t        main_res;
  logic        fin_en;
  logic        fail_en;
  logic [2:0]  fail_st;
  logic [2:0]  fin_st;
  logic [1:0]  fin_phase;
  res_t        fin_res;

  assign pos_inc   = payload_pos + 32'd1;
  assign left      = cfg.payload_size - pos_inc;
  assign word      = {in_byte, command_word[7:0]};
  assign full_off  = {in_byte, offset_accum[23:0]};
  assign copy_len  = {1'b0, command_word & cfg.length_mask} + {1'b0, cfg.length_bias};
  assign base_room = cfg.base_size - full_off;
  assign cap_room  = cfg.out_capacity - out_pos;
  assign cap_bad   = out_pos > cfg.out_capacity;

  always_comb begin
    payload_pos_next  = payload_pos;
    out_pos_next      = out_pos;
    phase_next        = phase;
    command_word_next = command_word;
    offset_accum_next = offset_accum;
    byte_count_next   = byte_count;
    literal_left_next = literal_left;
    halted_next       = halted;
    main_en           = 1'b0;
    main_res          = '0;
    fin_en            = 1'b0;
    fail_en           = 1'b0;
    fail_st           = ST_OK;
    fin_phase         = phase;
    if (in_fire && !halted) begin
      if (payload_pos >= cfg.payload_size) begin
        fin_en = 1'b1;
      end else begin
        payload_pos_next = pos_inc;
        case (phase)
          PH_CMD_LO: begin
            command_word_next = {8'd0, in_byte};
            phase_next        = PH_CMD_HI;
          end
          PH_CMD_HI: begin
            command_word_next = word;
            if (word[15]) begin
              if (left < 32'd4) begin
                fail_en = 1'b1;
                fail_st = ST_TRUNCATED;
              end else begin
                offset_accum_next = '0;
                byte_count_next   = '0;
                phase_next        = PH_OFFSET;
              end
            end else if (word == 16'd0) begin
              phase_next = PH_CMD_LO;
            end else if ({16'd0, word} > left) begin
              fail_en = 1'b1;
              fail_st = ST_OVERRUN;
            end else if (cap_bad || {16'd0, word} > cap_room) begin
              fail_en = 1'b1;
              fail_st = ST_OVERFLOW;
            end else begin
              literal_left_next = word;
              phase_next        = PH_LITERAL;
            end
          end
          PH_OFFSET: begin
            case (byte_count)
              2'd0: offset_accum_next[7:0]   = in_byte;
              2'd1: offset_accum_next[15:8]  = in_byte;
              2'd2: offset_accum_next[23:16] = in_byte;
              default: offset_accum_next[31:24] = in_byte;
            endcase
            if (byte_count == 2'd3) begin
              if (full_off > cfg.base_size || {15'd0, copy_len} > base_room) begin
                fail_en = 1'b1;
                fail_st = ST_BASE;
              end else if (cap_bad || {15'd0, copy_len} > cap_room) begin
                fail_en = 1'b1;
                fail_st = ST_OVERFLOW;
              end else begin
                out_pos_next         = out_pos + {15'd0, copy_len};
                main_en              = 1'b1;
                main_res.kind        = KIND_COPY;
                main_res.copy_offset = full_off;
                main_res.copy_length = copy_len;
                main_res.bytes_out   = out_pos_next;
                byte_count_next      = '0;
                phase_next           = PH_CMD_LO;
              end
            end else begin
              byte_count_next = byte_count + 2'd1;
            end
          end
          default: begin
            out_pos_next       = out_pos + 32'd1;
            main_en            = 1'b1;
            main_res.kind      = KIND_LITERAL;
            main_res.data_byte = in_byte;
            main_res.bytes_out = out_pos_next;
            literal_left_next  = literal_left - 16'd1;
            if (literal_left_next == 16'd0) begin
              phase_next = PH_CMD_LO;
            end
          end
        endcase
        fin_phase = phase_next;
        if (fail_en || pos_inc >= cfg.payload_size) begin
          fin_en = 1'b1;
        end
      end
      if (fin_en) begin
        halted_next = 1'b1;
      end
    end
  end

  always_comb begin
    if (fail_en) begin
      fin_st = fail_st;
    end else begin
      case (fin_phase)
        PH_CMD_LO:  fin_st = (out_pos_next == cfg.declared_size) ? ST_OK : ST_MISMATCH;
        PH_LITERAL: fin_st = ST_OVERRUN;
        default:    fin_st = ST_TRUNCATED;
      endcase
    end
    fin_res           = '0;
    fin_res.kind      = KIND_STATUS;
    fin_res.status    = fin_st;
    fin_res.bytes_out = out_pos_next;
    fin_res.last      = 1'b1;
  end

  assign res0      = main_en ? main_res : fin_res;
  assign res1      = fin_res;
  assign res_count = {1'b0, main_en} + {1'b0, fin_en};

endmodule

/* hw/rtl/cldd_out_fifo.sv */
// Four-entry result queue: takes up to two results a cycle, releases one.
`timescale 1ns / 1ps
module cldd_out_fifo
  import cldd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_count,
  input  res_t       push0,
  input  res_t       push1,
  output logic       has_room,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_res
);

  res_t       slots [4];
  logic [1:0] rd_ptr;
  logic [1:0] wr_ptr;
  logic [2:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != 3'd0;
  assign out_res   = slots[rd_ptr];
  assign has_room  = count <= 3'd2;

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      slots[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      slots[wr_ptr + 2'd1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, push_count} - {2'b0, pop};
    end
  end

endmodule

/* hw/rtl/copy_literal_delta_decoder.sv */
// Top level of the copy/literal delta decoder: config registers, parser, result queue.
//
//   channel   dir  payload                                     accept
//   s_axis    in   tdata[7:0] delta_byte                       tvalid & tready
//   m_axis    out  tuser kind, tlast last, tdata result fields tvalid & tready
//   cfg       in   cfg_index register, cfg_data value          cfg_valid & cfg_ready
//
// One payload word per cycle; each word is parsed in the cycle it is taken and its
// results land in a four-entry queue, ready in the next cycle.
// A word yields at most two results; s_axis_tready drops only when the queue holds
// three or more. rst clears the parse state, the queue and the registers to their
// reset values. cfg_ready is always high.
`timescale 1ns / 1ps
module copy_literal_delta_decoder
  import cldd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // [7:0] delta_byte
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] data_byte, [39:8] copy_offset, [56:40] copy_length, [59:57] status,
  // [91:60] bytes_out, [95:92] zero
  output logic [RES_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]            m_axis_tuser,  // [1:0] kind
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  cfg_t       cfg;
  logic       in_fire;
  logic [1:0] res_count;
  res_t       res0;
  res_t       res1;
  logic       has_room;
  res_t       out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.payload_size  <= '0;
      cfg.base_size     <= '0;
      cfg.out_capacity  <= '0;
      cfg.declared_size <= '0;
      cfg.length_mask   <= 16'h7FFF;
      cfg.length_bias   <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PAYLOAD_SIZE:  cfg.payload_size  <= cfg_data;
        REG_BASE_SIZE:     cfg.base_size     <= cfg_data;
        REG_OUT_CAPACITY:  cfg.out_capacity  <= cfg_data;
        REG_DECLARED_SIZE: cfg.declared_size <= cfg_data;
        REG_LENGTH_MASK:   cfg.length_mask   <= cfg_data[15:0];
        REG_LENGTH_BIAS:   cfg.length_bias   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = has_room;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  cldd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_fire   (in_fire),
    .in_byte   (s_axis_tdata),
    .res_count (res_count),
    .res0      (res0),
    .res1      (res1)
  );

  cldd_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (res_count),
    .push0      (res0),
    .push1      (res1),
    .has_room   (has_room),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_res    (out_res)
  );

  assign m_axis_tdata = {4'd0, out_res.bytes_out, out_res.status, out_res.copy_length,
                         out_res.copy_offset, out_res.data_byte};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

/* tb/tb_copy_literal_delta_decoder.sv */
// Self-checking testbench for the copy/literal delta decoder with a built-in stream predictor.
`timescale 1ns / 1ps
module tb_copy_literal_delta_decoder
  import cldd_pkg::*;
();

  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_ITEMS  = 700;
  localparam int PHASE_ITEMS   = 100;

  localparam logic [2:0] REG_UNUSED_6 = 3'd6;
  localparam logic [2:0] REG_UNUSED_7 = 3'd7;

  typedef enum logic [1:0] {AT_CMD_LO, AT_CMD_HI, AT_OFFSET, AT_LITERAL} parse_phase_e;

  typedef enum int {
    END_CLEAN, END_MISMATCH, END_CUT_LOW, END_CUT_COPY, END_BASE,
    END_OVERFLOW, END_OVERRUN, END_PAST_CMD, END_PAST_LITERAL, END_PAST_OFFSET
  } stream_end_e;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'h00;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [RES_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [2:0]            cfg_index = 3'd0;
  logic [31:0]           cfg_data = 32'h0;

  copy_literal_delta_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  cfg_t         regs;
  logic [31:0]  pos_in;
  logic [31:0]  bytes_made;
  parse_phase_e parse_phase;
  logic [15:0]  cmd_word;
  logic [31:0]  off_acc;
  logic [1:0]   off_count;
  logic [15:0]  lit_left;
  logic         halted;

  res_t decoded_results[$];
  int   mismatches = 0;
  int   sent_count = 0;
  int   quiet_cycles = 0;
  int   hold_req = 0;
  int   hold_left = 0;
  bit   steady = 1'b0;

  task automatic push_result(input logic [1:0] k, input logic [7:0] d, input logic [31:0] off,
                             input logic [16:0] len, input logic [2:0] st, input logic l);
    res_t r;
    r.kind        = k;
    r.data_byte   = d;
    r.copy_offset = off;
    r.copy_length = len;
    r.status      = st;
    r.bytes_out   = bytes_made;
    r.last        = l;
    decoded_results.push_back(r);
  endtask

  task automatic halt_with(input logic [2:0] st);
    push_result(KIND_STATUS, 8'h00, 32'h0, 17'h0, st, 1'b1);
    halted = 1'b1;
  endtask

  task automatic close_stream();
    if (parse_phase == AT_CMD_LO) begin
      halt_with((bytes_made == regs.declared_size) ? ST_OK : ST_MISMATCH);
    end else if (parse_phase == AT_LITERAL) begin
      halt_with(ST_OVERRUN);
    end else begin
      halt_with(ST_TRUNCATED);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [31:0] left;
    logic [31:0] clen;
    if (halted) return;
    if (pos_in >= regs.payload_size) begin
      close_stream();
      return;
    end
    pos_in = pos_in + 1;
    left = regs.payload_size - pos_in;
    case (parse_phase)
      AT_CMD_LO: begin
        cmd_word = {8'h00, b};
        parse_phase = AT_CMD_HI;
      end
      AT_CMD_HI: begin
        cmd_word[15:8] = b;
        if (cmd_word[15]) begin
          if (left < 32'd4) begin
            halt_with(ST_TRUNCATED);
            return;
          end
          off_acc = 32'h0;
          off_count = 2'd0;
          parse_phase = AT_OFFSET;
        end else if (cmd_word == 16'h0) begin
          parse_phase = AT_CMD_LO;
        end else if ({16'h0, cmd_word} > left) begin
          halt_with(ST_OVERRUN);
          return;
        end else if (bytes_made > regs.out_capacity ||
                     {16'h0, cmd_word} > regs.out_capacity - bytes_made) begin
          halt_with(ST_OVERFLOW);
          return;
        end else begin
          lit_left = cmd_word;
          parse_phase = AT_LITERAL;
        end
      end
      AT_OFFSET: begin
        off_acc[8*off_count +: 8] = b;
        if (off_count == 2'd3) begin
          clen = {16'h0, cmd_word & regs.length_mask} + {16'h0, regs.length_bias};
          if (off_acc > regs.base_size || clen > regs.base_size - off_acc) begin
            halt_with(ST_BASE);
            return;
          end
          if (bytes_made > regs.out_capacity || clen > regs.out_capacity - bytes_made) begin
            halt_with(ST_OVERFLOW);
            return;
          end
          bytes_made = bytes_made + clen;
          push_result(KIND_COPY, 8'h00, off_acc, clen[16:0], ST_OK, 1'b0);
          off_count = 2'd0;
          parse_phase = AT_CMD_LO;
        end else begin
          off_count = off_count + 2'd1;
        end
      end
      default: begin
        bytes_made = bytes_made + 1;
        push_result(KIND_LITERAL, b, 32'h0, 17'h0, ST_OK, 1'b0);
        lit_left = lit_left - 16'd1;
        if (lit_left == 16'h0) parse_phase = AT_CMD_LO;
      end
    endcase
    if (pos_in >= regs.payload_size) close_stream();
  endtask

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    decode_byte(b);
    sent_count++;
  endtask

  task automatic send_word(input logic [15:0] w);
    send_byte(w[7:0]);
    send_byte(w[15:8]);
  endtask

  task automatic send_copy(input logic [14:0] lo, input logic [31:0] off);
    send_word({1'b1, lo});
    for (int i = 0; i < 4; i++) send_byte(off[8*i +: 8]);
  endtask

  task automatic send_literal(input int len);
    send_word(len[15:0]);
    repeat (len) send_byte(8'($urandom_range(0, 255)));
  endtask

  // hold until every predicted word is out and the parser has settled
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (decoded_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PAYLOAD_SIZE:  regs.payload_size  = value;
      REG_BASE_SIZE:     regs.base_size     = value;
      REG_OUT_CAPACITY:  regs.out_capacity  = value;
      REG_DECLARED_SIZE: regs.declared_size = value;
      REG_LENGTH_MASK:   regs.length_mask   = value[15:0];
      REG_LENGTH_BIAS:   regs.length_bias   = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // pick a command that passes every check under the current register values
  task automatic send_random_command();
    logic [14:0] lo;
    logic [31:0] clen;
    logic [31:0] span;
    logic [31:0] off;
    int          len;
    lo = 15'($urandom_range(0, 15'h7FFF));
    clen = {16'h0, {1'b1, lo} & regs.length_mask} + {16'h0, regs.length_bias};
    if ($urandom_range(0, 1) == 1 && clen <= regs.base_size && bytes_made <= regs.out_capacity
        && clen <= regs.out_capacity - bytes_made) begin
      span = regs.base_size - clen;
      if (span > 32'd4096 && $urandom_range(0, 1) == 1) begin
        off = $urandom_range(0, 4096);
      end else begin
        off = 32'(({$urandom, $urandom}) % ({32'h0, span} + 64'd1));
      end
      send_copy(lo, off);
    end else begin
      len = ($urandom_range(0, 19) != 0) ? $urandom_range(0, 6) : $urandom_range(7, 40);
      if (32'(len) > regs.out_capacity - bytes_made) len = 0;
      send_literal(len);
    end
  endtask

  task automatic shuffle_settings();
    logic [31:0] cap;
    case ($urandom_range(0, 3))
      0: cfg_write(REG_LENGTH_MASK, 32'h7FFF);
      1: cfg_write(REG_LENGTH_MASK, 32'hFFFF);
      2: cfg_write(REG_LENGTH_MASK, 32'h0000);
      default: cfg_write(REG_LENGTH_MASK, $urandom_range(0, 16'hFFFF));
    endcase
    case ($urandom_range(0, 3))
      0: cfg_write(REG_LENGTH_BIAS, 32'h1);
      1: cfg_write(REG_LENGTH_BIAS, 32'h0);
      2: cfg_write(REG_LENGTH_BIAS, 32'hFFFF);
      default: cfg_write(REG_LENGTH_BIAS, $urandom_range(0, 16'hFFFF));
    endcase
    case ($urandom_range(0, 3))
      0: cfg_write(REG_BASE_SIZE, 32'hFFFF_FFFF);
      1: cfg_write(REG_BASE_SIZE, $urandom);
      2: cfg_write(REG_BASE_SIZE, $urandom_range(0, 200000));
      default: cfg_write(REG_BASE_SIZE, $urandom_range(0, 64));
    endcase
    if (bytes_made >= 32'hE000_0000 || $urandom_range(0, 1) == 1) begin
      cap = 32'hFFFF_FFFF;
    end else begin
      cap = bytes_made + 32'h0100_0000 + $urandom_range(0, 32'h0FFF_FFFF);
    end
    cfg_write(REG_OUT_CAPACITY, cap);
    cfg_write(REG_DECLARED_SIZE, $urandom);
  endtask

  task automatic test_reset_extremes();
    cfg_write(REG_PAYLOAD_SIZE, 32'hFFFF_FFFF);
    cfg_write(REG_BASE_SIZE, 32'h0);
    cfg_write(REG_OUT_CAPACITY, 32'h0);
    cfg_write(REG_DECLARED_SIZE, 32'h0);
    cfg_write(REG_LENGTH_MASK, 32'h0);
    cfg_write(REG_LENGTH_BIAS, 32'h0);
    cfg_write(REG_UNUSED_6, $urandom);
    cfg_write(REG_UNUSED_7, $urandom);
    send_copy(15'h0000, 32'h0);
    send_literal(0);
    wait_idle();
    cfg_write(REG_BASE_SIZE, 32'hFFFF_FFFF);
    cfg_write(REG_OUT_CAPACITY, 32'hFFFF_FFFF);
    cfg_write(REG_LENGTH_MASK, 32'hFFFF);
    cfg_write(REG_LENGTH_BIAS, 32'hFFFF);
    send_copy(15'h7FFF, 32'hFFFE_0001);
    send_word(16'h0002);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_copy(15'h0000, 32'h0);
    wait_idle();
    cfg_write(REG_LENGTH_MASK, 32'h7FFF);
    cfg_write(REG_LENGTH_BIAS, 32'h1);
  endtask

  task automatic test_random_commands();
    int goal;
    int phase_goal;
    goal = sent_count + RANDOM_ITEMS;
    for (int k = 0; sent_count < goal; k++) begin
      wait_idle();
      shuffle_settings();
      steady = (k == 3);
      phase_goal = sent_count + PHASE_ITEMS;
      while (sent_count < phase_goal) send_random_command();
    end
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_req = HOLD_CYCLES;
    send_literal(40);
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      send_random_command();
      send_random_command();
      wait_idle();
    end
  endtask

  task automatic test_stream_end();
    stream_end_e ending;
    ending = stream_end_e'($urandom_range(0, 9));
    wait_idle();
    case (ending)
      END_CLEAN, END_MISMATCH: begin
        cfg_write(REG_DECLARED_SIZE, (ending == END_CLEAN) ? bytes_made + 1 : bytes_made);
        cfg_write(REG_PAYLOAD_SIZE, pos_in + 3);
        send_word(16'h0001);
        send_byte(8'($urandom_range(0, 255)));
      end
      END_CUT_LOW: begin
        cfg_write(REG_PAYLOAD_SIZE, pos_in + 1);
        send_byte(8'($urandom_range(0, 255)));
      end
      END_CUT_COPY: begin
        cfg_write(REG_PAYLOAD_SIZE, pos_in + 5);
        send_word({1'b1, 15'($urandom_range(0, 15'h7FFF))});
      end
      END_BASE: begin
        cfg_write(REG_BASE_SIZE, $urandom_range(0, 1000));
        send_copy(15'($urandom_range(0, 15'h7FFF)),
                  regs.base_size + 1 + $urandom_range(0, 1000));
      end
      END_OVERFLOW: begin
        cfg_write(REG_OUT_CAPACITY, bytes_made);
        send_word(16'h0001);
      end
      END_OVERRUN: begin
        cfg_write(REG_PAYLOAD_SIZE, pos_in + 3);
        send_word(16'h0005);
      end
      END_PAST_CMD: begin
        cfg_write(REG_DECLARED_SIZE, bytes_made + $urandom_range(0, 1));
        cfg_write(REG_PAYLOAD_SIZE, pos_in);
        send_byte(8'($urandom_range(0, 255)));
      end
      END_PAST_LITERAL: begin
        send_word(16'h0003);
        send_byte(8'($urandom_range(0, 255)));
        wait_idle();
        cfg_write(REG_PAYLOAD_SIZE, pos_in);
        send_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        send_word({1'b1, 15'($urandom_range(0, 15'h7FFF))});
        send_byte(8'($urandom_range(0, 255)));
        wait_idle();
        cfg_write(REG_PAYLOAD_SIZE, pos_in);
        send_byte(8'($urandom_range(0, 255)));
      end
    endcase
    // halted from here on: these words must be dropped
    repeat (8) send_byte(8'($urandom_range(0, 255)));
  endtask

  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 26);
    end
  end

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (decoded_results.size() == 0) begin
        $display("%0t: unexpected word expected none actual kind %0d tdata %0h", $time,
                 m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        want = decoded_results.pop_front();
        compare_field("kind", want.kind, m_axis_tuser);
        compare_field("data_byte", want.data_byte, m_axis_tdata[7:0]);
        compare_field("copy_offset", want.copy_offset, m_axis_tdata[39:8]);
        compare_field("copy_length", want.copy_length, m_axis_tdata[56:40]);
        compare_field("status", want.status, m_axis_tdata[59:57]);
        compare_field("bytes_out", want.bytes_out, m_axis_tdata[91:60]);
        compare_field("last", want.last, m_axis_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: stalled for %0d cycles", $time, quiet_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    regs.payload_size  = 32'h0;
    regs.base_size     = 32'h0;
    regs.out_capacity  = 32'h0;
    regs.declared_size = 32'h0;
    regs.length_mask   = 16'h7FFF;
    regs.length_bias   = 16'h0001;
    pos_in      = 32'h0;
    bytes_made  = 32'h0;
    parse_phase = AT_CMD_LO;
    cmd_word    = 16'h0;
    off_acc     = 32'h0;
    off_count   = 2'd0;
    lit_left    = 16'h0;
    halted      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_extremes();
    test_random_commands();
    test_backpressure();
    test_drain_pause();
    test_stream_end();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* copy_literal_delta_decoder.f */
hw/rtl/cldd_pkg.sv
hw/rtl/cldd_parser.sv
hw/rtl/cldd_out_fifo.sv
hw/rtl/copy_literal_delta_decoder.sv
tb/tb_copy_literal_delta_decoder.sv
